>>> src/blz_pkg.sv
// shared widths, item kinds, item and job types and the queue write type for the line rasteriser
package blz_pkg;

  localparam int CoordBits = 12;
  localparam int ZBits     = 16;
  localparam int ErrBits   = CoordBits + 2;

  localparam logic KindStart = 1'b0;
  localparam logic KindStep  = 1'b1;

  typedef struct packed {
    logic                        kind;
    logic signed [CoordBits-1:0] x_start;
    logic signed [CoordBits-1:0] y_start;
    logic signed [ZBits-1:0]     z_start;
    logic signed [CoordBits-1:0] x_end;
    logic signed [CoordBits-1:0] y_end;
    logic signed [ZBits-1:0]     z_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] pixel_x;
    logic signed [CoordBits-1:0] pixel_y;
    logic signed [ZBits-1:0]     pixel_z;
    logic                        last;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic                        last;
    logic signed [ZBits-1:0]     z0;
    logic signed [ZBits-1:0]     z1;
    logic        [CoordBits-1:0] idx;
    logic        [CoordBits-1:0] steps;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

endpackage

>>> src/bresenham_line_z_interp_core.sv
// top level of the bresenham line rasteriser with height interpolation
//
// channel  direction  handshake            payload
// input    in         push_i / full_o      in_i  (blz_pkg::in_item_t)
// result   out        empty_o / pop_i      out_o (blz_pkg::out_item_t)
//
// each pixel passes through the back end in order: job take, product, sum, a 30-step
// restoring divide of the height numerator by the step count, then the result load
// the front takes one step of a line per accepted item and runs ahead by up to two queued jobs
// reset clears the line state, the queue and the result valid flag
// a waiting result holds the back end after its divide; the front goes on until the queue fills
module bresenham_line_z_interp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  blz_pkg::in_item_t  in_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output blz_pkg::out_item_t out_o
);
  import blz_pkg::*;

  qwr_t qwr;
  job_t fjob, bjob;
  logic q_full, q_empty, q_pop;

  blz_front u_front (
    .clk_i, .rst_ni, .push_i, .in_i, .full_o,
    .qwr_o(qwr), .q_full_i(q_full), .job_o(fjob)
  );

  blz_queue u_queue (
    .clk_i, .rst_ni, .wr_i(qwr), .job_i(fjob), .full_o(q_full),
    .empty_o(q_empty), .pop_i(q_pop), .job_o(bjob)
  );

  blz_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .job_i(bjob), .q_pop_o(q_pop),
    .empty_o, .pop_i, .out_o
  );

endmodule

>>> src/blz_front.sv
// front end: takes items, runs the bresenham stepper and issues pixel jobs
module blz_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  blz_pkg::in_item_t in_i,
  output logic            full_o,
  output blz_pkg::qwr_t   qwr_o,
  input  logic            q_full_i,
  output blz_pkg::job_t   job_o
);
  import blz_pkg::*;

  logic signed [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CoordBits-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic        [CoordBits-1:0] dx_q, dx_d, dy_q, dy_d, idx_q, idx_d;
  logic                        negx_q, negx_d, negy_q, negy_d;
  logic signed [ErrBits-1:0]   err_q, err_d;
  logic signed [ZBits-1:0]     zf_q, zf_d, zt_q, zt_d;
  logic                        act_q, act_d;

  logic                      acc, fin, emit;
  logic signed [CoordBits:0] ddx, ddy;
  logic signed [ErrBits:0]   e2, ndy, pdx;
  logic                      cx, cy;

  assign full_o = q_full_i;
  assign acc    = push_i && !q_full_i;

  always_comb begin
    cur_x_d = cur_x_q; cur_y_d = cur_y_q; goal_x_d = goal_x_q; goal_y_d = goal_y_q;
    dx_d = dx_q; dy_d = dy_q; idx_d = idx_q; negx_d = negx_q; negy_d = negy_q;
    err_d = err_q; zf_d = zf_q; zt_d = zt_q; act_d = act_q;
    ddx  = {in_i.x_end[CoordBits-1], in_i.x_end} - {in_i.x_start[CoordBits-1], in_i.x_start};
    ddy  = {in_i.y_end[CoordBits-1], in_i.y_end} - {in_i.y_start[CoordBits-1], in_i.y_start};
    e2   = {err_q, 1'b0};
    ndy  = -$signed({2'b00, dy_q});
    pdx  = $signed({2'b00, dx_q});
    cx   = e2 > ndy;
    cy   = e2 < pdx;
    emit = 1'b0;
    if (acc && in_i.kind == KindStart) begin
      emit     = 1'b1;
      cur_x_d  = in_i.x_start;
      cur_y_d  = in_i.y_start;
      goal_x_d = in_i.x_end;
      goal_y_d = in_i.y_end;
      zf_d     = in_i.z_start;
      zt_d     = in_i.z_end;
      dx_d     = ddx[CoordBits] ? CoordBits'(-ddx) : ddx[CoordBits-1:0];
      dy_d     = ddy[CoordBits] ? CoordBits'(-ddy) : ddy[CoordBits-1:0];
      negx_d   = !(in_i.x_start < in_i.x_end);
      negy_d   = !(in_i.y_start < in_i.y_end);
      err_d    = $signed({2'b00, dx_d}) - $signed({2'b00, dy_d});
      idx_d    = '0;
    end else if (acc && act_q) begin
      emit = 1'b1;
      if (cx) begin
        err_d   = err_d - $signed({2'b00, dy_q});
        cur_x_d = negx_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (cy) begin
        err_d   = err_d + $signed({2'b00, dx_q});
        cur_y_d = negy_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      idx_d = idx_q + 1'b1;
    end
    fin = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);
    if (emit) act_d = !fin;
  end

  assign qwr_o.push = emit;
  assign qwr_o.full = q_full_i;

  always_comb begin
    job_o.x     = cur_x_d;
    job_o.y     = cur_y_d;
    job_o.last  = fin;
    job_o.z0    = zf_d;
    job_o.z1    = zt_d;
    job_o.idx   = idx_d;
    job_o.steps = (dx_d > dy_d) ? dx_d : dy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; goal_x_q <= '0; goal_y_q <= '0;
      dx_q <= '0; dy_q <= '0; idx_q <= '0; negx_q <= 1'b0; negy_q <= 1'b0;
      err_q <= '0; zf_q <= '0; zt_q <= '0; act_q <= 1'b0;
    end else begin
      cur_x_q <= cur_x_d; cur_y_q <= cur_y_d; goal_x_q <= goal_x_d; goal_y_q <= goal_y_d;
      dx_q <= dx_d; dy_q <= dy_d; idx_q <= idx_d; negx_q <= negx_d; negy_q <= negy_d;
      err_q <= err_d; zf_q <= zf_d; zt_q <= zt_d; act_q <= act_d;
    end
  end

endmodule

>>> src/blz_queue.sv
// two-entry job queue between front and back
module blz_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  blz_pkg::qwr_t wr_i,
  input  blz_pkg::job_t job_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output blz_pkg::job_t job_o
);
  import blz_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign wr      = wr_i.push && !full_o;
  assign rd      = pop_i && !empty_o;
  assign job_o   = mem_q[rp_q];
  assign cnt_d   = cnt_q + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/blz_back.sv
// back end: height products, serial divide and the result register
module blz_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  blz_pkg::job_t     job_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output blz_pkg::out_item_t out_o
);
  import blz_pkg::*;

  localparam int NumBits = ZBits + CoordBits + 2;
  localparam int CntBits = $clog2(NumBits + 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StSum  = 4'b0100,
    StDiv  = 4'b1000
  } state_e;

  state_e                      st_q;
  job_t                        job_q;
  logic signed [NumBits-2:0]   p0_q, p1_q;
  logic signed [NumBits-1:0]   num;
  logic        [NumBits-1:0]   quo_q;
  logic        [CoordBits:0]   rem_q, trial;
  logic                        neg_q;
  logic        [CntBits-1:0]   cnt_q;
  logic                        ov_q, load;
  out_item_t                   out_q;
  logic signed [ZBits-1:0]     zres;
  logic        [CoordBits-1:0] wt0;

  assign q_pop_o = (st_q == StIdle) && !q_empty_i;
  assign empty_o = !ov_q;
  assign out_o   = out_q;
  assign wt0     = job_q.steps - job_q.idx;
  assign num     = NumBits'(p0_q) + NumBits'(p1_q);
  assign trial   = {rem_q[CoordBits-1:0], quo_q[NumBits-1]} - {1'b0, job_q.steps};
  assign load    = (st_q == StDiv) && (cnt_q == '0) && (!ov_q || pop_i);

  always_comb begin
    zres = neg_q ? -$signed(quo_q[ZBits-1:0]) : $signed(quo_q[ZBits-1:0]);
    if (job_q.steps == '0) zres = job_q.z0;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (q_pop_o) job_q <= job_i;
      StMul: begin
        p0_q <= job_q.z0 * $signed({1'b0, wt0});
        p1_q <= job_q.z1 * $signed({1'b0, job_q.idx});
      end
      StSum: begin
        neg_q <= num[NumBits-1];
        quo_q <= num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
        rem_q <= '0;
      end
      StDiv: if (cnt_q != '0) begin
        if (!trial[CoordBits]) begin
          rem_q <= trial;
          quo_q <= {quo_q[NumBits-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[CoordBits-1:0], quo_q[NumBits-1]};
          quo_q <= {quo_q[NumBits-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load) begin
      out_q.pixel_x <= job_q.x;
      out_q.pixel_y <= job_q.y;
      out_q.pixel_z <= zres;
      out_q.last    <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      unique case (st_q)
        StIdle: if (q_pop_o) st_q <= StMul;
        StMul:  st_q <= StSum;
        StSum: begin
          st_q  <= StDiv;
          cnt_q <= CntBits'(NumBits);
        end
        StDiv: begin
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          if (load) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
      if (load) ov_q <= 1'b1;
      else if (pop_i) ov_q <= 1'b0;
    end
  end

endmodule

>>> src/blz_checker.sv
// port-level checks on the rasteriser top level
module blz_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push_i,
  input logic               full_o,
  input logic               empty_o,
  input logic               pop_i,
  input blz_pkg::out_item_t out_o
);
  import blz_pkg::*;

  logic [31:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else pend_q <= pend_q + {31'd0, push_i && !full_o} - {31'd0, pop_i && !empty_o};
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_o)))
    else $error("result changed while stalled");

  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (pend_q != 32'd0))
    else $error("result without a pending item");

  a_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && pend_q == 32'd0) |=> empty_o)
    else $error("result appeared without a preceding item");

endmodule

bind bresenham_line_z_interp_core blz_checker u_blz_checker (
  .clk_i, .rst_ni, .push_i, .full_o, .empty_o, .pop_i, .out_o
);
